// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Clocked on the rising edge; failures report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only
`define DRO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property checked at every edge, reset included
`define DRO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/dro_pkg.sv =====
// Shared widths, register codes and control types for the dual cosine oscillator.
// No dependencies; imported by every other file but assert_macros.svh.
`timescale 1ns / 1ps

package dro_pkg;

  // Field widths
  localparam int COEF_W     = 16;
  localparam int AMP_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Serial multiplier: coefficient side consumed one digit per cycle
  localparam int DIGIT_W   = 4;
  localparam int NDIG      = COEF_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(NDIG);
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NDIG - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COEF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd2;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16000;

  // Sequencer to lane controls
  typedef struct packed {
    logic clear;       // restart: zero the history
    logic start;       // load first pass (coef * last output)
    logic step;        // advance serial multiplier one digit
    logic sign_digit;  // current digit is the top, signed one
    logic update;      // close recursion, load scaling pass
    logic imp_now;
    logic imp_last;
  } dro_ctrl_t;

endpackage

// ===== rtl/dro_ifs.sv =====
// Valid/ready channel interfaces for sample ticks and output samples.
// Depends on dro_pkg for the sample width.
`timescale 1ns / 1ps

interface dro_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dro_result_if import dro_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/dro_smul.sv =====
// Digit-serial signed multiplier: a full-width operand times a 16-bit operand
// taken DIGIT_W bits per cycle, LSB first. Depends on dro_pkg.
`timescale 1ns / 1ps

module dro_smul import dro_pkg::*; #(
  parameter int AW = 24
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic                       sign_digit,
  input  logic signed [AW-1:0]       a,
  input  logic signed [COEF_W-1:0]   b,
  output logic signed [AW+COEF_W-1:0] product
);

  logic signed [AW-1:0]        a_reg;
  logic        [COEF_W-1:0]    b_sh;
  logic        [AW:0]          acc;
  logic        [COEF_W-1:0]    low_sh;
  logic signed [DIGIT_W:0]     d;
  logic signed [AW+DIGIT_W:0]  pp;
  logic        [AW+DIGIT_W:0]  sum;

  // Current digit: unsigned except the top one, which carries the sign
  assign d = sign_digit ? {b_sh[DIGIT_W-1], b_sh[DIGIT_W-1:0]}
                        : {1'b0, b_sh[DIGIT_W-1:0]};

  assign pp  = a_reg * d;
  assign sum = pp + {{DIGIT_W{acc[AW]}}, acc};

  // Low digits retire into low_sh, running sum shifts down one digit
  always_ff @(posedge clk) begin
    if (load) begin
      a_reg <= a;
      b_sh  <= b;
      acc   <= '0;
    end else if (step) begin
      b_sh   <= b_sh >> DIGIT_W;
      acc    <= sum[AW+DIGIT_W:DIGIT_W];
      low_sh <= {sum[DIGIT_W-1:0], low_sh[COEF_W-1:DIGIT_W]};
    end
  end

  // Product magnitude is at most 2^(AW+COEF_W-2), so acc's top bit is redundant
  assign product = {acc[AW-1:0], low_sh};

endmodule

// ===== rtl/dro_lane.sv =====
// One oscillator channel: output history, recursion update and output scaling
// around a shared digit-serial multiplier. Depends on dro_pkg and dro_smul.
`timescale 1ns / 1ps

module dro_lane import dro_pkg::*; #(
  parameter int SF = 22,
  parameter int CF = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dro_ctrl_t                  ctrl,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic        [AMP_W-1:0]    amp,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int SW  = SF + 2;
  localparam int PW  = SW + COEF_W;
  localparam int TW  = PW + 2;
  localparam int CSW = COEF_W + SF;

  localparam logic signed [TW-1:0] ONE  = {{(TW-SF-1){1'b0}}, 1'b1, {SF{1'b0}}};
  localparam logic signed [TW-1:0] Y_HI = {{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [TW-1:0] Y_LO = {{(TW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [PW-1:0] RND  = {{(PW-SF){1'b0}}, {SF{1'b1}}};
  localparam logic signed [PW-1:0] S_HI = {{(PW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [PW-1:0] S_LO = {{(PW-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic signed [SW-1:0]     y_last;
  logic signed [SW-1:0]     y_before;
  logic signed [SW-1:0]     y_new;
  logic signed [TW-1:0]     bias;
  logic signed [TW-1:0]     bias_next;
  logic signed [TW-1:0]     c_term;
  logic signed [TW-1:0]     prod_term;
  logic signed [TW-1:0]     y_sum;
  logic signed [CSW-1:0]    c_wide;
  logic signed [CSW-1:0]    c_shift;
  logic signed [PW:0]       prod2;
  logic signed [PW:0]       prod2_sh;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     prod_adj;
  logic signed [PW-1:0]     prod_sh;
  logic signed [SW-1:0]     mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic                     mul_load;

  // Impulse-history term: floor(c * 1.0 / 2^CF)
  assign c_wide  = {coef, {SF{1'b0}}};
  assign c_shift = c_wide >>> CF;
  assign c_term  = {{(TW-CSW){c_shift[CSW-1]}}, c_shift};

  // Everything but the product, registered as the first multiplier pass is loaded
  assign bias_next = -{{(TW-SW){y_before[SW-1]}}, y_before}
                     + (ctrl.imp_now ? ONE : '0)
                     - (ctrl.imp_last ? c_term : '0);

  // 2*c*y1 floored by CF, plus bias, saturated to the Q2 range
  assign prod2     = {prod, 1'b0};
  assign prod2_sh  = prod2 >>> CF;
  assign prod_term = {{(TW-PW-1){prod2_sh[PW]}}, prod2_sh};
  assign y_sum     = prod_term + bias;

  always_comb begin
    if (y_sum > Y_HI) begin
      y_new = Y_HI[SW-1:0];
    end else if (y_sum < Y_LO) begin
      y_new = Y_LO[SW-1:0];
    end else begin
      y_new = y_sum[SW-1:0];
    end
  end

  // amplitude * y, truncated toward zero, saturated to 16 bits
  assign prod_adj = prod + (prod[PW-1] ? RND : '0);
  assign prod_sh  = prod_adj >>> SF;

  always_comb begin
    if (prod_sh > S_HI) begin
      sample = S_HI[SAMPLE_W-1:0];
    end else if (prod_sh < S_LO) begin
      sample = S_LO[SAMPLE_W-1:0];
    end else begin
      sample = prod_sh[SAMPLE_W-1:0];
    end
  end

  // Multiplier operands: first pass coef * y1, second pass amplitude * y
  assign mul_load = ctrl.start | ctrl.update;
  assign mul_a    = ctrl.update ? y_new : y_last;
  assign mul_b    = ctrl.update ? $signed({1'b0, amp}) : coef;

  dro_smul #(
    .AW (SW)
  ) u_smul (
    .clk        (clk),
    .load       (mul_load),
    .step       (ctrl.step),
    .sign_digit (ctrl.sign_digit),
    .a          (mul_a),
    .b          (mul_b),
    .product    (prod)
  );

  // Output history
  always_ff @(posedge clk) begin
    if (rst) begin
      y_last   <= '0;
      y_before <= '0;
    end else if (ctrl.clear) begin
      y_last   <= '0;
      y_before <= '0;
    end else if (ctrl.update) begin
      y_before <= y_last;
      y_last   <= y_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bias <= bias_next;
    end
  end

endmodule

// ===== rtl/dual_recursive_cosine_oscillator.sv =====
// Dual recursive cosine oscillator, one result beat per tick beat.
// Normal tick: S_MUL1, S_RES, S_MUL2, then S_FIN loads the result register once the
// output is free and the next tick is taken in S_IDLE; each lane's multiplier makes two
// 4-digit passes (recursion, scaling). Restart tick: goes straight to S_FIN, zero result.
// Sync reset clears history and impulse, sets coefficients to 0 and amplitude to 16000.
`timescale 1ns / 1ps

module dual_recursive_cosine_oscillator import dro_pkg::*; #(
  parameter int STATE_FRAC_BITS = 22,
  parameter int COEF_FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  dro_tick_if.sink              tick,
  dro_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_RES  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                 state;
  logic [DIG_CNT_W-1:0]       digit_cnt;
  logic                       imp_now;
  logic                       imp_last;
  logic                       zero_out;
  logic signed [COEF_W-1:0]   left_coef;
  logic signed [COEF_W-1:0]   right_coef;
  logic        [AMP_W-1:0]    amp;
  logic                       accept;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] left_val;
  logic signed [SAMPLE_W-1:0] right_val;
  dro_ctrl_t                  ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_coef  <= '0;
      right_coef <= '0;
      amp        <= AMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_COEF:  left_coef  <= cfg_data;
        CFG_RIGHT_COEF: right_coef <= cfg_data;
        CFG_AMPLITUDE:  amp        <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign tick.ready = (state == S_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign out_free   = !result.valid || result.ready;

  // Lane controls
  always_comb begin
    ctrl.clear      = accept && tick.restart;
    ctrl.start      = accept && !tick.restart;
    ctrl.step       = (state == S_MUL1) || (state == S_MUL2);
    ctrl.sign_digit = (digit_cnt == DIG_LAST);
    ctrl.update     = (state == S_RES);
    ctrl.imp_now    = imp_now;
    ctrl.imp_last   = imp_last;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      digit_cnt <= '0;
      imp_now   <= 1'b0;
      imp_last  <= 1'b0;
      zero_out  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          digit_cnt <= '0;
          if (accept) begin
            if (tick.restart) begin
              imp_now  <= 1'b1;
              imp_last <= 1'b0;
              zero_out <= 1'b1;
              state    <= S_FIN;
            end else begin
              zero_out <= 1'b0;
              state    <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          digit_cnt <= digit_cnt + 1'b1;
          if (digit_cnt == DIG_LAST) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          imp_last  <= imp_now;
          imp_now   <= 1'b0;
          digit_cnt <= '0;
          state     <= S_MUL2;
        end
        S_MUL2: begin
          digit_cnt <= digit_cnt + 1'b1;
          if (digit_cnt == DIG_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dro_lane #(
    .SF (STATE_FRAC_BITS),
    .CF (COEF_FRAC_BITS)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (left_coef),
    .amp    (amp),
    .sample (left_val)
  );

  dro_lane #(
    .SF (STATE_FRAC_BITS),
    .CF (COEF_FRAC_BITS)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (right_coef),
    .amp    (amp),
    .sample (right_val)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      result.left_sample  <= zero_out ? '0 : left_val;
      result.right_sample <= zero_out ? '0 : right_val;
    end
  end

endmodule

// ===== rtl/dro_chk.sv =====
// Port-level checker for the dual cosine oscillator, bound to the top level.
// Depends on dro_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dro_chk import dro_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_restart,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] left_sample,
  input logic signed [SAMPLE_W-1:0] right_sample
);

  // Stalled result beat keeps its samples
  `DRO_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(left_sample) && $stable(right_sample), "result beat changed while stalled")

  // One tick in flight: busy right after an accept
  `DRO_ASSERT(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "tick accepted while another is in flight")

  // Restart with an empty output gives a zero beat, loaded from S_FIN
  `DRO_ASSERT(a_restart_zero, clk, rst, in_valid && in_ready && in_restart && !out_valid |=> ##1 out_valid && left_sample == 0 && right_sample == 0, "restart did not give a zero result")

  // A new result beat appears only as the block goes idle again
  `DRO_ASSERT(a_result_idle, clk, rst, $rose(out_valid) |-> in_ready, "result loaded while tick still in flight")

  // Reset empties the output register
  `DRO_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind dual_recursive_cosine_oscillator dro_chk u_dro_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (tick.valid),
  .in_ready     (tick.ready),
  .in_restart   (tick.restart),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .left_sample  (result.left_sample),
  .right_sample (result.right_sample)
);
